// ----- hdl/orcc_pkg.sv -----
// Shared types and constants for the online rank counter.
// Holds the item structs, opcodes and tree geometry; used by every hdl file.
package orcc_pkg;

  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;
  localparam int COST_BITS  = 30;
  localparam int TREE_BITS  = VALUE_BITS + 1;
  localparam int TREE_NODES = 1 << TREE_BITS;
  localparam int LEVEL_BITS = $clog2(VALUE_BITS);

  localparam logic [COST_BITS-1:0] COST_MODULUS = COST_BITS'(1000000007);

  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] less_count;
    logic [COUNT_BITS-1:0] greater_count;
    logic [COST_BITS-1:0]  total_cost;
  } out_t;

  typedef struct packed {
    logic                 rd_en;
    logic [TREE_BITS-1:0] rd_addr_a;
    logic [TREE_BITS-1:0] rd_addr_b;
    logic                 wr_en;
    logic [TREE_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

// ----- hdl/orcc_tree_ram.sv -----
// Count tree storage: one write port and two registered read ports.
// Depends on orcc_pkg for the tree geometry and the request struct.
module orcc_tree_ram (
  input  logic                             clk_i,
  input  orcc_pkg::mem_req_t               req_i,
  output logic [orcc_pkg::COUNT_BITS-1:0]  rd_data_a_o,
  output logic [orcc_pkg::COUNT_BITS-1:0]  rd_data_b_o
);

  logic [orcc_pkg::COUNT_BITS-1:0] mem_q [orcc_pkg::TREE_NODES];
  logic [orcc_pkg::COUNT_BITS-1:0] rd_a_q;
  logic [orcc_pkg::COUNT_BITS-1:0] rd_b_q;

  // Read data holds between reads, so a fetched pair stays usable until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_a_q <= mem_q[req_i.rd_addr_a];
      rd_b_q <= mem_q[req_i.rd_addr_b];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ----- hdl/orcc_sat_add.sv -----
// Shared saturating adder used for both sibling sums and counter increments.
// Depends on orcc_pkg for the counter width.
module orcc_sat_add (
  input  logic [orcc_pkg::COUNT_BITS-1:0] a_i,
  input  logic [orcc_pkg::COUNT_BITS-1:0] b_i,
  output logic [orcc_pkg::COUNT_BITS-1:0] y_o
);

  logic [orcc_pkg::COUNT_BITS:0] sum;

  assign sum = {1'b0, a_i} + {1'b0, b_i};
  assign y_o = sum[orcc_pkg::COUNT_BITS] ? '1 : sum[orcc_pkg::COUNT_BITS-1:0];

endmodule

// ----- hdl/orcc_ctrl.sv -----
// Sequencer for the rank counter: clearing sweep, tree walk and cost update.
// Depends on orcc_pkg; drives the tree memory and the shared adder.
module orcc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  orcc_pkg::in_t                   in_data_i,
  output logic                            in_stall_o,
  input  logic                            out_free_i,
  output logic                            res_valid_o,
  output orcc_pkg::out_t                  res_data_o,
  output orcc_pkg::mem_req_t              mem_req_o,
  input  logic [orcc_pkg::COUNT_BITS-1:0] rd_data_a_i,
  input  logic [orcc_pkg::COUNT_BITS-1:0] rd_data_b_i,
  output logic [orcc_pkg::COUNT_BITS-1:0] add_a_o,
  output logic [orcc_pkg::COUNT_BITS-1:0] add_b_o,
  input  logic [orcc_pkg::COUNT_BITS-1:0] add_y_i
);

  localparam int VB = orcc_pkg::VALUE_BITS;
  localparam int CB = orcc_pkg::COUNT_BITS;
  localparam int TB = orcc_pkg::TREE_BITS;
  localparam int LB = orcc_pkg::LEVEL_BITS;
  localparam int SB = orcc_pkg::COST_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_INC,
    ST_MOD,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [TB-1:0]   clr_cnt_q;
  logic            clr_res_q;
  logic [VB-1:0]   val_q;
  logic [LB-1:0]   level_q;
  logic [VB-1:0]   node_q;
  logic [CB-1:0]   less_q;
  logic [CB-1:0]   greater_q;
  logic [SB-1:0]   total_q;

  logic            cur_bit;
  logic            next_bit;
  logic [LB-1:0]   level_m1;
  logic [TB-1:0]   path_addr;
  logic [TB-1:0]   sib_addr;
  logic [CB-1:0]   smaller;
  logic [SB:0]     cost_sum;
  logic [SB-1:0]   total_next;

  assign cur_bit   = val_q[level_q];
  assign level_m1  = level_q - LB'(1);
  assign next_bit  = val_q[level_m1];
  // Children of node k are 2k and 2k+1, so the value bit picks the path child.
  assign path_addr = {node_q, cur_bit};
  assign sib_addr  = {node_q, ~cur_bit};

  assign smaller    = (less_q < greater_q) ? less_q : greater_q;
  assign cost_sum   = {1'b0, total_q} + (SB + 1)'(smaller);
  // The total stays below the modulus and the addend is small, so one subtract suffices.
  assign total_next = (cost_sum >= {1'b0, orcc_pkg::COST_MODULUS})
                    ? SB'(cost_sum - {1'b0, orcc_pkg::COST_MODULUS})
                    : cost_sum[SB-1:0];

  always_comb begin
    mem_req_o = '0;
    add_a_o   = '0;
    add_b_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = clr_cnt_q;
        mem_req_o.wr_data = '0;
      end
      ST_RD: begin
        mem_req_o.rd_en     = 1'b1;
        mem_req_o.rd_addr_a = sib_addr;
        mem_req_o.rd_addr_b = path_addr;
      end
      ST_ACC: begin
        add_a_o = cur_bit ? less_q : greater_q;
        add_b_o = rd_data_a_i;
      end
      ST_INC: begin
        add_a_o           = rd_data_b_i;
        add_b_o           = CB'(1);
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = path_addr;
        mem_req_o.wr_data = add_y_i;
        // Fetch the next level's pair while this level's counter is written back.
        if (level_q != '0) begin
          mem_req_o.rd_en     = 1'b1;
          mem_req_o.rd_addr_a = {path_addr[VB-1:0], ~next_bit};
          mem_req_o.rd_addr_b = {path_addr[VB-1:0], next_bit};
        end
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE) && out_free_i;
  assign res_data_o  = '{less_count: less_q, greater_count: greater_q, total_cost: total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      clr_res_q <= 1'b0;
      val_q     <= '0;
      level_q   <= '0;
      node_q    <= '0;
      less_q    <= '0;
      greater_q <= '0;
      total_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + TB'(1);
          if (&clr_cnt_q) begin
            clr_res_q <= 1'b0;
            state_q   <= clr_res_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            less_q    <= '0;
            greater_q <= '0;
            if (in_data_i.op == orcc_pkg::OP_INSERT) begin
              val_q   <= in_data_i.value;
              level_q <= LB'(VB - 1);
              node_q  <= VB'(1);
              state_q <= ST_RD;
            end else begin
              total_q   <= '0;
              clr_cnt_q <= '0;
              clr_res_q <= 1'b1;
              state_q   <= ST_CLEAR;
            end
          end
        end
        ST_RD: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (cur_bit) begin
            less_q <= add_y_i;
          end else begin
            greater_q <= add_y_i;
          end
          state_q <= ST_INC;
        end
        ST_INC: begin
          if (level_q == '0) begin
            state_q <= ST_MOD;
          end else begin
            level_q <= level_m1;
            node_q  <= path_addr[VB-1:0];
            state_q <= ST_ACC;
          end
        end
        ST_MOD: begin
          total_q <= total_next;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.wr_en && mem_req_o.rd_en) |->
      (mem_req_o.wr_addr != mem_req_o.rd_addr_a && mem_req_o.wr_addr != mem_req_o.rd_addr_b))
    else $error("tree write collides with a read of the same node");

  a_total_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (total_q < orcc_pkg::COST_MODULUS))
    else $error("running total not reduced below the modulus");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC || state_q == ST_INC) |-> (int'(level_q) < VB))
    else $error("tree walk level out of range");

  a_mod_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> ($past(state_q) == ST_INC && $past(level_q) == '0))
    else $error("cost update reached before the walk finished");
`endif

endmodule

// ----- hdl/online_rank_count_cost_unit.sv -----
// Online rank counter: an insert walks the tree from acceptance to its result in the output
// register, with the shared adder and one memory read-modify-write per tree level; a new item
// is taken once the previous finishes.
// A clear item sweeps all 2^(VALUE_BITS+1) tree counters.
// After reset the same clearing sweep runs before the first item is taken.
// Depends on orcc_pkg and instantiates orcc_ctrl, orcc_tree_ram and orcc_sat_add.
module online_rank_count_cost_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  orcc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output orcc_pkg::out_t out_data_o
);

  orcc_pkg::mem_req_t              mem_req;
  logic [orcc_pkg::COUNT_BITS-1:0] rd_data_a;
  logic [orcc_pkg::COUNT_BITS-1:0] rd_data_b;
  logic [orcc_pkg::COUNT_BITS-1:0] add_a;
  logic [orcc_pkg::COUNT_BITS-1:0] add_b;
  logic [orcc_pkg::COUNT_BITS-1:0] add_y;
  logic                            res_valid;
  orcc_pkg::out_t                  res_data;
  logic                            out_free;
  logic                            out_valid_q;
  logic                            out_valid_d;
  orcc_pkg::out_t                  out_data_q;

  // The output slot can take a new item when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  orcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .mem_req_o   (mem_req),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .add_a_o     (add_a),
    .add_b_o     (add_b),
    .add_y_i     (add_y)
  );

  orcc_tree_ram u_tree_ram (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  orcc_sat_add u_sat_add (
    .a_i (add_a),
    .b_i (add_b),
    .y_o (add_y)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
